@@ hdl/sccd_pkg.sv @@
// Shared types and constants of the sector cache directory.
package sccd_pkg;

   localparam int SECTOR_W = 32;
   localparam int SLOT_W   = 6;
   localparam int MODE_W   = 2;

   localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SWEEP,
      ST_INSTALL,
      ST_FLUSH_SCAN,
      ST_FLUSH_READ,
      ST_FLUSH_END,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic touch;
      logic install;
      logic clr_ref;
      logic clr_dirty;
      logic write;
   } flag_cmd_type;

   typedef struct packed {
      logic valid;
      logic dirty;
      logic referenced;
   } flag_stat_type;

endpackage

@@ hdl/sccd_ram.sv @@
// Generic simple dual-port RAM with registered read data.
module sccd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/sccd_flags.sv @@
// Valid, dirty and reference bits of every directory entry.
module sccd_flags #(
   parameter int ENTRIES = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [$clog2(ENTRIES)-1:0] idx,
   input  sccd_pkg::flag_cmd_type     cmd,
   output sccd_pkg::flag_stat_type    stat
);
   import sccd_pkg::*;

   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] dirty_ff;
   logic [ENTRIES-1:0] ref_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         dirty_ff <= '0;
         ref_ff   <= '0;
      end else begin
         if (cmd.install) begin
            valid_ff[idx] <= 1'b1;
            ref_ff[idx]   <= 1'b1;
            dirty_ff[idx] <= cmd.write;
         end
         if (cmd.touch) begin
            ref_ff[idx] <= 1'b1;
            if (cmd.write) begin
               dirty_ff[idx] <= 1'b1;
            end
         end
         if (cmd.clr_ref) begin
            ref_ff[idx] <= 1'b0;
         end
         if (cmd.clr_dirty) begin
            dirty_ff[idx] <= 1'b0;
         end
      end
   end

   always_comb begin
      stat.valid      = valid_ff[idx];
      stat.dirty      = dirty_ff[idx];
      stat.referenced = ref_ff[idx];
   end

endmodule

@@ hdl/sector_cache_directory_clock_core.sv @@
// Top level of the sector cache directory: sequencer, tag RAM and entry flags.
//
//   channel   direction  ports
//   request   in         req_valid, req_ready, req_mode, req_sector
//   response  out        rsp_valid, rsp_ready, rsp_hit, rsp_slot, rsp_fetch,
//                        rsp_writeback, rsp_writeback_sector, rsp_last
//
// A hit scans the tags up to the matching slot, then emits. A miss scans every entry,
// sweeps the hand past referenced entries, clearing their reference bits, up to an
// invalid or unreferenced entry, then installs and emits. The single tag RAM read port
// makes the scans sequential. A flush emits one writeback per dirty entry, the last marked
// with rsp_last. Requests are taken only while the sequencer is idle, and a full output
// register stalls the sequencer. Reset clears all flags and the hand at once.
module sector_cache_directory_clock_core #(
   parameter int ENTRIES = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [sccd_pkg::MODE_W-1:0]    req_mode,
   input  logic [sccd_pkg::SECTOR_W-1:0]  req_sector,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_hit,
   output logic [sccd_pkg::SLOT_W-1:0]    rsp_slot,
   output logic                           rsp_fetch,
   output logic                           rsp_writeback,
   output logic [sccd_pkg::SECTOR_W-1:0]  rsp_writeback_sector,
   output logic                           rsp_last
);
   import sccd_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   state_type state_ff, state_in;

   logic [MODE_W-1:0]   mode_ff;
   logic [SECTOR_W-1:0] sector_ff;
   logic [IDX_W-1:0]    scan_ff;
   logic                pend_ff;
   logic [IDX_W-1:0]    pend_idx_ff;
   logic [IDX_W-1:0]    hand_ff;

   logic                res_hit_ff;
   logic [IDX_W-1:0]    res_slot_ff;
   logic                res_fetch_ff;
   logic                res_wb_ff;
   logic [SECTOR_W-1:0] res_wb_sector_ff;
   logic                res_last_ff;
   logic                res_pend_ff;

   logic                rsp_valid_ff;
   logic                rsp_hit_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic                rsp_fetch_ff;
   logic                rsp_wb_ff;
   logic [SECTOR_W-1:0] rsp_wb_sector_ff;
   logic                rsp_last_ff;

   logic [IDX_W-1:0]    ram_rd_addr;
   logic [SECTOR_W-1:0] ram_rd_data;
   logic                ram_we;
   logic [IDX_W-1:0]    flag_idx;
   flag_cmd_type        flag_cmd;
   flag_stat_type       flag_stat;

   logic accept;
   logic is_write;
   logic hit_now;
   logic miss_now;
   logic sweep_stop;
   logic fl_dirty;
   logic out_free;
   logic emit_now;
   logic victim_wb;
   logic [SLOT_W+IDX_W-1:0] res_slot_wide;

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
      next_idx = (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   sccd_ram #(
      .WIDTH (SECTOR_W),
      .DEPTH (ENTRIES)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (hand_ff),
      .wr_data (sector_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   sccd_flags #(
      .ENTRIES (ENTRIES)
   ) u_flags (
      .clock (clock),
      .reset (reset),
      .idx   (flag_idx),
      .cmd   (flag_cmd),
      .stat  (flag_stat)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign is_write   = (mode_ff == MODE_WRITE);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign hit_now    = (state_ff == ST_LOOKUP) && pend_ff && flag_stat.valid &&
                       (ram_rd_data == sector_ff);
   assign miss_now   = (state_ff == ST_LOOKUP) && pend_ff && !hit_now &&
                       (pend_idx_ff == LAST_IDX);
   assign sweep_stop = !flag_stat.valid || !flag_stat.referenced;
   assign fl_dirty   = flag_stat.valid && flag_stat.dirty;
   assign victim_wb  = flag_stat.valid && flag_stat.dirty;
   assign emit_now   = (state_ff == ST_EMIT) && out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_READ || req_mode == MODE_WRITE) begin
                  state_in = ST_LOOKUP;
               end else if (req_mode == MODE_FLUSH) begin
                  state_in = ST_FLUSH_SCAN;
               end
            end
         end
         ST_LOOKUP: begin
            if (hit_now) begin
               state_in = ST_EMIT;
            end else if (miss_now) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (sweep_stop) begin
               state_in = ST_INSTALL;
            end
         end
         ST_INSTALL: begin
            state_in = ST_EMIT;
         end
         ST_FLUSH_SCAN: begin
            if (fl_dirty) begin
               state_in = res_pend_ff ? ST_EMIT : ST_FLUSH_READ;
            end else if (scan_ff == LAST_IDX) begin
               state_in = ST_FLUSH_END;
            end
         end
         ST_FLUSH_READ: begin
            state_in = (scan_ff == LAST_IDX) ? ST_FLUSH_END : ST_FLUSH_SCAN;
         end
         ST_FLUSH_END: begin
            state_in = res_pend_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = res_last_ff ? ST_IDLE : ST_FLUSH_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ram_rd_addr = hand_ff;
      ram_we      = 1'b0;
      flag_idx    = hand_ff;
      flag_cmd    = '0;
      flag_cmd.write = is_write;
      unique case (state_ff)
         ST_LOOKUP: begin
            ram_rd_addr    = scan_ff;
            flag_idx       = pend_idx_ff;
            flag_cmd.touch = hit_now;
         end
         ST_SWEEP: begin
            flag_cmd.clr_ref = !sweep_stop;
         end
         ST_INSTALL: begin
            ram_we           = 1'b1;
            flag_cmd.install = 1'b1;
         end
         ST_FLUSH_SCAN: begin
            ram_rd_addr = scan_ff;
            flag_idx    = scan_ff;
         end
         ST_FLUSH_READ: begin
            flag_idx           = scan_ff;
            flag_cmd.clr_dirty = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         hand_ff      <= '0;
         res_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            scan_ff     <= '0;
            pend_ff     <= 1'b0;
            res_pend_ff <= 1'b0;
         end
         if (state_ff == ST_LOOKUP) begin
            scan_ff <= next_idx(scan_ff);
            pend_ff <= 1'b1;
         end
         if (state_ff == ST_SWEEP && !sweep_stop) begin
            hand_ff <= next_idx(hand_ff);
         end
         if (state_ff == ST_FLUSH_SCAN && !fl_dirty && scan_ff != LAST_IDX) begin
            scan_ff <= next_idx(scan_ff);
         end
         if (state_ff == ST_FLUSH_READ) begin
            res_pend_ff <= 1'b1;
            if (scan_ff != LAST_IDX) begin
               scan_ff <= next_idx(scan_ff);
            end
         end
         if (emit_now) begin
            res_pend_ff  <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff   <= req_mode;
         sector_ff <= req_sector;
      end
      if (state_ff == ST_LOOKUP) begin
         pend_idx_ff <= scan_ff;
      end
      if (hit_now) begin
         res_hit_ff       <= 1'b1;
         res_slot_ff      <= pend_idx_ff;
         res_fetch_ff     <= 1'b0;
         res_wb_ff        <= 1'b0;
         res_wb_sector_ff <= '0;
         res_last_ff      <= 1'b1;
      end
      if (state_ff == ST_INSTALL) begin
         res_hit_ff       <= 1'b0;
         res_slot_ff      <= hand_ff;
         res_fetch_ff     <= (mode_ff == MODE_READ);
         res_wb_ff        <= victim_wb;
         res_wb_sector_ff <= victim_wb ? ram_rd_data : '0;
         res_last_ff      <= 1'b1;
      end
      if (state_ff == ST_FLUSH_READ) begin
         res_hit_ff       <= 1'b0;
         res_slot_ff      <= scan_ff;
         res_fetch_ff     <= 1'b0;
         res_wb_ff        <= 1'b1;
         res_wb_sector_ff <= ram_rd_data;
         res_last_ff      <= 1'b0;
      end
      if (state_ff == ST_FLUSH_END) begin
         res_last_ff <= 1'b1;
      end
      if (emit_now) begin
         rsp_hit_ff       <= res_hit_ff;
         rsp_slot_ff      <= res_slot_wide[SLOT_W-1:0];
         rsp_fetch_ff     <= res_fetch_ff;
         rsp_wb_ff        <= res_wb_ff;
         rsp_wb_sector_ff <= res_wb_sector_ff;
         rsp_last_ff      <= res_last_ff;
      end
   end

   assign res_slot_wide = {{SLOT_W{1'b0}}, res_slot_ff};

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hit              = rsp_hit_ff;
   assign rsp_slot             = rsp_slot_ff;
   assign rsp_fetch            = rsp_fetch_ff;
   assign rsp_writeback        = rsp_wb_ff;
   assign rsp_writeback_sector = rsp_wb_sector_ff;
   assign rsp_last             = rsp_last_ff;

endmodule

@@ hdl/sccd_checker.sv @@
// Port-level checks of the sector cache directory and their binding.
module sccd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [sccd_pkg::MODE_W-1:0]   req_mode,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_hit,
   input logic [sccd_pkg::SLOT_W-1:0]   rsp_slot,
   input logic                          rsp_fetch,
   input logic                          rsp_writeback,
   input logic [sccd_pkg::SECTOR_W-1:0] rsp_writeback_sector,
   input logic                          rsp_last
);
   import sccd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot) &&
      $stable(rsp_writeback_sector) && $stable(rsp_last))
      else $error("Stalled response changed.");

   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_fetch && !rsp_writeback && rsp_last)
      else $error("Hit response carries fetch or writeback.");

   a_wb_sector_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_writeback |-> rsp_writeback_sector == '0)
      else $error("Writeback sector set without writeback.");

   a_flush_only_multi: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_writeback && !rsp_hit && !rsp_fetch)
      else $error("Non-final response is not a flush writeback.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode != MODE_NONE |=> !req_ready)
      else $error("Ready right after an access or flush request.");

endmodule

bind sector_cache_directory_clock_core sccd_checker u_sccd_checker (.*);
